### hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Tag character cipher package
// Types, fixed key buffer words and the arithmetic shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int UID_W  = 56;
    localparam int ID_W   = 16;
    localparam int WORD_W = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Pad byte that follows the UID in the top byte of the second word.
    localparam logic [7:0] PAD_BYTE_7 = 8'hb7;

    // Little-endian buffer words, plain and with the forced byte applied.
    localparam logic [WORD_W-1:0] WORD_2       = 32'he7e6_d7d5;
    localparam logic [WORD_W-1:0] WORD_2_FORCE = 32'haae6_d7d5;
    localparam logic [WORD_W-1:0] WORD_3       = 32'hd8a8_3cba;
    localparam logic [WORD_W-1:0] WORD_3_FORCE = 32'haaa8_3cba;
    localparam logic [WORD_W-1:0] WORD_4       = 32'hcf68_4775;
    localparam logic [WORD_W-1:0] WORD_4_FORCE = 32'haa68_4775;
    localparam logic [WORD_W-1:0] WORD_5_FORCE = 32'haafe_e923;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_tea;

    function automatic logic [WORD_W-1:0] fold_word(
        input logic [WORD_W-1:0] acc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] ror25;
        logic [WORD_W-1:0] ror10;
        begin
            ror25 = {acc[24:0], acc[31:25]};
            ror10 = {acc[9:0], acc[31:10]};
            fold_word = word + ror25 + ror10 - acc;
        end
    endfunction

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        begin
            tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
        end
    endfunction

endpackage

`default_nettype wire

### hdl/tcc_key_derive.sv
// ----------------------------------------------------------------------------
// Key derivation pipeline
// Folds the UID and pad words into four key words over five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_key_derive
    import tcc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [UID_W-1:0] i_uid,
    input  wire logic [ID_W-1:0]  i_id,
    output logic                  o_valid,
    output t_tea                  o_state
);

    logic [4:0]        r_vld;

    logic [WORD_W-1:0] r_a2;
    logic [ID_W-1:0]   r_id1;

    logic [WORD_W-1:0] r_a3;
    logic [WORD_W-1:0] r_k0_2;
    logic [ID_W-1:0]   r_id2;

    logic [WORD_W-1:0] r_a4;
    logic [WORD_W-1:0] r_k0_3;
    logic [WORD_W-1:0] r_k1_3;
    logic [ID_W-1:0]   r_id3;

    logic [WORD_W-1:0] r_a5;
    logic [WORD_W-1:0] r_k0_4;
    logic [WORD_W-1:0] r_k1_4;
    logic [WORD_W-1:0] r_k2_4;
    logic [ID_W-1:0]   r_id4;

    t_tea              r_state;

    logic [WORD_W-1:0] n_a2;
    logic [WORD_W-1:0] n_word1;
    t_tea              n_state;

    // The first fold starts from zero and so yields the first word itself.
    assign n_word1 = {PAD_BYTE_7, i_uid[UID_W-1:WORD_W]};
    assign n_a2    = fold_word(i_uid[WORD_W-1:0], n_word1);

    always_comb begin
        n_state.v0 = {{(WORD_W-ID_W){1'b0}}, r_id4};
        n_state.v1 = {{(WORD_W-ID_W){1'b0}}, r_id4};
        n_state.k0 = r_k0_4;
        n_state.k1 = r_k1_4;
        n_state.k2 = r_k2_4;
        n_state.k3 = fold_word(r_a5, WORD_5_FORCE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2    <= n_a2;
            r_id1   <= i_id;

            r_a3    <= fold_word(r_a2, WORD_2);
            r_k0_2  <= fold_word(r_a2, WORD_2_FORCE);
            r_id2   <= r_id1;

            r_a4    <= fold_word(r_a3, WORD_3);
            r_k0_3  <= r_k0_2;
            r_k1_3  <= fold_word(r_a3, WORD_3_FORCE);
            r_id3   <= r_id2;

            r_a5    <= fold_word(r_a4, WORD_4);
            r_k0_4  <= r_k0_3;
            r_k1_4  <= r_k1_3;
            r_k2_4  <= fold_word(r_a4, WORD_4_FORCE);
            r_id4   <= r_id3;

            r_state <= n_state;
        end
    end

    assign o_valid = r_vld[4];
    assign o_state = r_state;

endmodule

`default_nettype wire

### hdl/tcc_half_round.sv
// ----------------------------------------------------------------------------
// TEA half-round stage
// Updates one data word of the cipher state and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_half_round
    import tcc_pkg::*;
#(
    parameter logic [31:0] SUM   = 32'h0000_0000,
    parameter bit          UPPER = 1'b0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_tea i_state,
    output logic      o_valid,
    output t_tea      o_state
);

    logic r_valid;
    t_tea r_state;
    t_tea n_state;

    always_comb begin
        n_state = i_state;
        if (UPPER) begin
            n_state.v1 = i_state.v1 + tea_mix(i_state.v0, SUM, i_state.k2, i_state.k3);
        end else begin
            n_state.v0 = i_state.v0 + tea_mix(i_state.v1, SUM, i_state.k0, i_state.k1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

### hdl/tag_character_cipher.sv
// ----------------------------------------------------------------------------
// Tag character cipher
// Derives a key from a tag UID and encrypts the character id with TEA.
// ----------------------------------------------------------------------------
// Requests enter on the slave stream: i_s_tdata carries the 56-bit UID in
// the low bits and the 16-bit character id above it. Each request yields one
// response on the master stream: o_m_tdata carries the low word in bits
// 31:0 and the high word in bits 63:32.
// The block takes a request every cycle while o_s_tready is high. Five key
// derivation stages are followed by one register stage per TEA half-round
// and an output register, which presents each response to the receiver.
// When the receiver stalls, the pipeline keeps running until a response
// reaches the skid register behind the output register; the whole pipeline
// then holds, and o_s_tready stays low until the skid register drains.
// Reset clears every valid bit; no request is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_character_cipher
    import tcc_pkg::*;
#(
    parameter int ROUNDS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // uid[55:0], character_id[71:56]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata    // low_word[31:0], high_word[63:32]
);

    localparam int STAGES = 2 * ROUNDS;

    logic              w_en;
    logic              w_valid [0:STAGES];
    t_tea              w_state [0:STAGES];

    logic              r_out_valid;
    logic [63:0]       r_out_data;
    logic              r_skid_valid;
    logic [63:0]       r_skid_data;

    logic              w_arrive;
    logic              w_take;
    logic [63:0]       w_result;

    assign w_en       = ~r_skid_valid;
    assign o_s_tready = w_en;

    tcc_key_derive u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_uid   (i_s_tdata[UID_W-1:0]),
        .i_id    (i_s_tdata[UID_W+ID_W-1:UID_W]),
        .o_valid (w_valid[0]),
        .o_state (w_state[0])
    );

    for (genvar g = 0; g < STAGES; g++) begin : g_round
        localparam logic [31:0] RoundSum = TEA_DELTA * 32'(g / 2 + 1);
        localparam bit          IsUpper  = ((g % 2) == 1);

        tcc_half_round #(
            .SUM   (RoundSum),
            .UPPER (IsUpper)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1])
        );
    end

    assign w_result = {w_state[STAGES].v1, w_state[STAGES].v0};
    assign w_arrive = w_en & w_valid[STAGES];
    assign w_take   = r_out_valid & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_arrive;
        end else if (w_arrive) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_data <= w_result;
        end else if (w_arrive) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire
